[design/cdss_pkg.sv]
// package for the clock display scan serializer
// frame width, scan slot types, segment table and frame builder; no dependencies
`default_nettype none
package cdss_pkg;

    // frame and scan geometry
    localparam int FRAME_BITS = 20;
    localparam int BIT_W      = $clog2(FRAME_BITS);
    localparam int SLOTS      = 8;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int TICK_W     = 16;
    localparam int CFG_W      = 13;
    localparam int START_W    = TICK_W;
    localparam int END_W      = TICK_W + 1;

    // frame queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // configuration register indexes and reset values
    localparam logic CFG_ON_TICKS   = 1'b0;
    localparam logic CFG_SLOT_TICKS = 1'b1;
    localparam int   ON_RESET       = 50;
    localparam int   SLOT_RESET     = 100;

    // slot codes
    localparam logic [SLOT_W-1:0] SLOT_HOUR_T = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_HOUR_U = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_MIN_T  = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_MIN_U  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_SEC_T  = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_SEC_U  = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_COLON  = 3'd6;

    // grid bits and fixed patterns
    localparam logic [31:0] GRID_HOUR_T = 32'h0000_0200;
    localparam logic [31:0] GRID_HOUR_U = 32'h0000_0100;
    localparam logic [31:0] GRID_MIN_T  = 32'h0000_0400;
    localparam logic [31:0] GRID_MIN_U  = 32'h0000_0040;
    localparam logic [31:0] GRID_SEC_T  = 32'h0000_0020;
    localparam logic [31:0] GRID_SEC_U  = 32'h0000_1000;
    localparam logic [31:0] COLON_BASE  = 32'h0000_000F;
    localparam logic [31:0] COLON_BLINK = 32'h0000_2000;
    localparam logic [31:0] TAIL_FRAME  = 32'h0001_0880;

    // one scheduled frame: the slot and the time it shows
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } t_scan;

    // front to queue
    typedef struct packed {
        logic  push;
        t_scan entry;
    } t_q_wr;

    // queue to back
    typedef struct packed {
        logic  valid;
        t_scan entry;
    } t_q_rd;

    // seven-segment patterns for digits 0..9
    function automatic logic [31:0] seg_pattern(input logic [3:0] digit);
        logic [31:0] pat;
        case (digit)
            4'd0:    pat = 32'h0c017;
            4'd1:    pat = 32'h08002;
            4'd2:    pat = 32'h18015;
            4'd3:    pat = 32'h18016;
            4'd4:    pat = 32'h1c002;
            4'd5:    pat = 32'h14016;
            4'd6:    pat = 32'h14017;
            4'd7:    pat = 32'h08012;
            4'd8:    pat = 32'h1c017;
            4'd9:    pat = 32'h1c012;
            default: pat = 32'h0;
        endcase
        return pat;
    endfunction

    // tens digit of a value below 64
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    // units digit of a value below 64
    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [6:0] tens10;
        logic [6:0] rem;
        tens10 = 7'(tens_of(v)) * 7'd10;
        rem    = 7'(v) - tens10;
        return rem[3:0];
    endfunction

    // frame for one slot
    function automatic logic [FRAME_BITS-1:0] build_frame(input t_scan e);
        logic [31:0] f;
        logic [5:0]  h6;
        h6 = {1'b0, e.hour};
        case (e.slot)
            SLOT_HOUR_T: f = seg_pattern(tens_of(h6))       | GRID_HOUR_T;
            SLOT_HOUR_U: f = seg_pattern(units_of(h6))      | GRID_HOUR_U;
            SLOT_MIN_T:  f = seg_pattern(tens_of(e.minute)) | GRID_MIN_T;
            SLOT_MIN_U:  f = seg_pattern(units_of(e.minute)) | GRID_MIN_U;
            SLOT_SEC_T:  f = seg_pattern(tens_of(e.second)) | GRID_SEC_T;
            SLOT_SEC_U:  f = seg_pattern(units_of(e.second)) | GRID_SEC_U;
            SLOT_COLON:  f = e.second[0] ? (COLON_BASE | COLON_BLINK) : COLON_BASE;
            default:     f = TAIL_FRAME;
        endcase
        return FRAME_BITS'(f);
    endfunction

endpackage
`default_nettype wire

[design/clock_display_scan_serializer.sv]
// top level of the clock display scan serializer
// depends on cdss_pkg, cdss_front, cdss_queue and cdss_back
//
// Input channel: one beat per scan tick carrying hour, minute and second,
// taken when i_push is high and o_full low. The tick counter runs in the
// front end; a tick that falls in the open window of a scan slot queues a
// frame, any other tick produces nothing.
// Result channel: one beat per frame bit, least significant bit first,
// o_last marking the final bit. The beat is shown while o_empty is low and
// taken when i_pop is high.
// Configuration: i_cfg_we writes on_ticks (index 0) or slot_ticks (index 1)
// with no wait; slot windows are recomputed in the same edge.
// Timing: a taken tick's frame is written into the queue, then loaded into
// the serializer, whose shift register shows its first bit; while the
// serializer is busy the frame waits in the queue. Each frame is FRAME_BITS
// beats at one beat per cycle while i_pop is high, frames run back to back,
// so the serializer sets the sustained rate of frame-producing ticks. Ticks
// are taken one per cycle until the four-entry frame queue fills.
// Reset clears the tick counter, the queue and the serializer and loads
// the default windows. A stalled receiver holds the current beat; the
// queue then fills and o_full stops further ticks.
`default_nettype none
module clock_display_scan_serializer
    import cdss_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_addr,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [4:0]       i_hour,
    input  wire logic [5:0]       i_minute,
    input  wire logic [5:0]       i_second,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output logic                  o_data_bit,
    output logic                  o_last
);

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_pop;

    // tick classification
    cdss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (i_push),
        .i_hour      (i_hour),
        .i_minute    (i_minute),
        .i_second    (i_second),
        .i_q_full    (o_full),
        .o_q_wr      (q_wr)
    );

    // frame queue
    cdss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (q_wr),
        .i_pop   (q_pop),
        .o_full  (o_full),
        .o_q_rd  (q_rd)
    );

    // serializer
    cdss_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_rd     (q_rd),
        .o_q_pop    (q_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_data_bit (o_data_bit),
        .o_last     (o_last)
    );

endmodule
`default_nettype wire

[design/cdss_front.sv]
// front end: tick counter, slot windows and classification of each tick
// depends on cdss_pkg
`default_nettype none
module cdss_front
    import cdss_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_addr,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    input  wire logic             i_push,
    input  wire logic [4:0]       i_hour,
    input  wire logic [5:0]       i_minute,
    input  wire logic [5:0]       i_second,
    input  wire logic             i_q_full,
    output t_q_wr                 o_q_wr
);

    logic [CFG_W-1:0]   r_on;
    logic [START_W-1:0] r_start [SLOTS];
    logic [END_W-1:0]   r_end   [SLOTS];
    logic [TICK_W-1:0]  r_wrap;
    logic [TICK_W-1:0]  r_tick;

    logic [START_W-1:0] n_start [SLOTS];
    logic [TICK_W-1:0]  c;
    logic [SLOTS-1:0]   hit;
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic               accept;

    // slot starts for a new slot length
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            n_start[k] = START_W'(k * int'(i_cfg_wdata));
        end
    end

    // window registers, rebuilt on each configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on   <= CFG_W'(ON_RESET);
            r_wrap <= TICK_W'(SLOTS * SLOT_RESET);
            for (int k = 0; k < SLOTS; k++) begin
                r_start[k] <= START_W'(k * SLOT_RESET);
                r_end[k]   <= END_W'(k * SLOT_RESET + ON_RESET);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_ON_TICKS) begin
                r_on <= i_cfg_wdata;
                for (int k = 0; k < SLOTS; k++) begin
                    r_end[k] <= END_W'(r_start[k]) + END_W'(i_cfg_wdata);
                end
            end else begin
                r_wrap <= TICK_W'({i_cfg_wdata, 3'b000});
                for (int k = 0; k < SLOTS; k++) begin
                    r_start[k] <= n_start[k];
                    r_end[k]   <= END_W'(n_start[k]) + END_W'(r_on);
                end
            end
        end
    end

    // window match, lowest slot wins
    always_comb begin
        c     = r_tick + TICK_W'(1);
        found = 1'b0;
        slot  = '0;
        for (int k = 0; k < SLOTS; k++) begin
            hit[k] = (c > r_start[k]) && (END_W'(c) <= r_end[k]);
        end
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (hit[k]) begin
                found = 1'b1;
                slot  = SLOT_W'(k);
            end
        end
    end

    assign accept = i_push && !i_q_full;

    // tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (accept) begin
            if (!found && (c > r_wrap)) r_tick <= '0;
            else                        r_tick <= c;
        end
    end

    // frame request towards the queue
    always_comb begin
        o_q_wr.push         = accept && found;
        o_q_wr.entry.slot   = slot;
        o_q_wr.entry.hour   = i_hour;
        o_q_wr.entry.minute = i_minute;
        o_q_wr.entry.second = i_second;
    end

endmodule
`default_nettype wire

[design/cdss_queue.sv]
// short frame queue between the front end and the serializer
// depends on cdss_pkg
`default_nettype none
module cdss_queue
    import cdss_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_q_wr i_q_wr,
    input  wire logic  i_pop,
    output logic       o_full,
    output t_q_rd      o_q_rd
);

    t_scan             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign do_push = i_q_wr.push && !o_full;
    assign do_pop  = i_pop && (r_cnt != '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_q_wr.entry;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + QPTR_W'(1);
            if (do_pop)  r_rp <= r_rp + QPTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // head of the queue
    always_comb begin
        o_q_rd.valid = (r_cnt != '0);
        o_q_rd.entry = r_mem[r_rp];
    end

endmodule
`default_nettype wire

[design/cdss_back.sv]
// serializer: builds each frame and shifts it out one bit per beat
// depends on cdss_pkg
`default_nettype none
module cdss_back
    import cdss_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_q_rd i_q_rd,
    output logic       o_q_pop,
    input  wire logic  i_pop,
    output logic       o_empty,
    output logic       o_data_bit,
    output logic       o_last
);

    logic                  r_busy;
    logic [FRAME_BITS-1:0] r_shift;
    logic [BIT_W-1:0]      r_cnt;

    logic is_last;
    logic take;
    logic load;

    assign is_last = (r_cnt == BIT_W'(FRAME_BITS - 1));
    assign take    = r_busy && i_pop;
    assign load    = i_q_rd.valid && (!r_busy || (take && is_last));
    assign o_q_pop = load;

    // busy flag and bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (take) begin
            if (is_last) r_busy <= 1'b0;
            r_cnt <= r_cnt + BIT_W'(1);
        end
    end

    // frame shift register
    always_ff @(posedge i_clk) begin
        if (load)      r_shift <= build_frame(i_q_rd.entry);
        else if (take) r_shift <= r_shift >> 1;
    end

    assign o_empty    = !r_busy;
    assign o_data_bit = r_shift[0];
    assign o_last     = is_last;

endmodule
`default_nettype wire

[design/cdss_checker.sv]
// port-level checks for the clock display scan serializer
// no dependencies; bound to the top level below
`default_nettype none
module cdss_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_full,
    input wire logic o_empty,
    input wire logic i_pop,
    input wire logic o_data_bit,
    input wire logic o_last
);

    // nothing to deliver straight after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result beat shown after reset");

    // queue is open straight after reset
    a_open_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_full)
        else $error("input blocked after reset");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_data_bit) && $stable(o_last)))
        else $error("stalled result beat changed");

    // a frame never breaks off before its last bit
    a_frame_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_last) |=> !o_empty)
        else $error("frame cut short");

endmodule

bind clock_display_scan_serializer cdss_checker u_cdss_checker (.*);
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// testbench for the clock display scan serializer: directed and random scan ticks
// predicts every serial frame beat and checks it; depends on cdss_pkg and the design
module testbench;
    import cdss_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int IDLE_PCT    = 7;
    localparam int MAX_REPORTS = 20;

    // grid bits and fixed frames as the display expects them
    localparam logic [31:0] HOUR_T_GRID = 32'h0000_0200;
    localparam logic [31:0] HOUR_U_GRID = 32'h0000_0100;
    localparam logic [31:0] MIN_T_GRID  = 32'h0000_0400;
    localparam logic [31:0] MIN_U_GRID  = 32'h0000_0040;
    localparam logic [31:0] SEC_T_GRID  = 32'h0000_0020;
    localparam logic [31:0] SEC_U_GRID  = 32'h0000_1000;
    localparam logic [31:0] COLON_SEGS  = 32'h0000_000F;
    localparam logic [31:0] BLINK_BIT   = 32'h0000_2000;
    localparam logic [31:0] LOAD_FRAME  = 32'h0001_0880;

    typedef struct packed {
        logic data_bit;
        logic last;
    } t_frame_beat;

    // stimulus side
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_addr  = CFG_ON_TICKS;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             push      = 1'b0;
    logic [4:0]       hour      = '0;
    logic [5:0]       minute    = '0;
    logic [5:0]       second    = '0;
    logic             pop       = 1'b0;
    logic             full;
    logic             empty;
    logic             data_bit;
    logic             last;

    // shadow of the scan state
    logic [CFG_W-1:0]  on_len     = CFG_W'(ON_RESET);
    logic [CFG_W-1:0]  slot_len   = CFG_W'(SLOT_RESET);
    logic [TICK_W-1:0] scan_count = '0;
    t_frame_beat       beats_due[$];
    t_frame_beat       want;

    // run bookkeeping
    bit calm = 1'b0;
    int mismatches    = 0;
    int ticks_sent    = 0;
    int quiet_ticks   = 0;
    int cfg_writes    = 0;
    int beats_checked = 0;
    int quiet_cycles  = 0;
    int slot_hits[SLOTS];

    clock_display_scan_serializer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_hour      (hour),
        .i_minute    (minute),
        .i_second    (second),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_data_bit  (data_bit),
        .o_last      (last)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // segment pattern of one decimal digit
    function automatic logic [31:0] digit_segments(input int d);
        case (d)
            0:       return 32'h0c017;
            1:       return 32'h08002;
            2:       return 32'h18015;
            3:       return 32'h18016;
            4:       return 32'h1c002;
            5:       return 32'h14016;
            6:       return 32'h14017;
            7:       return 32'h08012;
            8:       return 32'h1c017;
            9:       return 32'h1c012;
            default: return 32'h0;
        endcase
    endfunction

    // frame shown in one scan slot
    function automatic logic [31:0] scan_frame(input logic [SLOT_W-1:0] slot,
                                               input int h, input int m, input int s);
        case (slot)
            SLOT_HOUR_T: return digit_segments(h / 10) | HOUR_T_GRID;
            SLOT_HOUR_U: return digit_segments(h % 10) | HOUR_U_GRID;
            SLOT_MIN_T:  return digit_segments(m / 10) | MIN_T_GRID;
            SLOT_MIN_U:  return digit_segments(m % 10) | MIN_U_GRID;
            SLOT_SEC_T:  return digit_segments(s / 10) | SEC_T_GRID;
            SLOT_SEC_U:  return digit_segments(s % 10) | SEC_U_GRID;
            SLOT_COLON:  return (s % 2 == 1) ? (COLON_SEGS | BLINK_BIT) : COLON_SEGS;
            default:     return LOAD_FRAME;
        endcase
    endfunction

    // advance the tick counter and queue the frame beats this tick sends
    task automatic predict_tick(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
        int          c;
        int          k;
        int          slot_start;
        int          hit_slot;
        logic [31:0] frame;
        t_frame_beat beat;
        c = (int'(scan_count) + 1) & 16'hFFFF;
        scan_count = TICK_W'(c);
        hit_slot = -1;
        // walk downwards so the lowest matching slot wins
        for (k = SLOTS - 1; k >= 0; k--) begin
            slot_start = k * int'(slot_len);
            if (c > slot_start && c <= slot_start + int'(on_len))
                hit_slot = k;
        end
        if (hit_slot < 0) begin
            if (c > SLOTS * int'(slot_len))
                scan_count = '0;
            quiet_ticks++;
        end else begin
            frame = scan_frame(SLOT_W'(hit_slot), int'(h), int'(m), int'(s));
            slot_hits[hit_slot]++;
            for (k = 0; k < FRAME_BITS; k++) begin
                beat.data_bit = frame[k];
                beat.last     = (k == FRAME_BITS - 1);
                beats_due.push_back(beat);
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("error: %s", what);
    endtask

    // one scan tick beat, with an occasional idle gap in front
    task automatic send_tick(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push   <= 1'b1;
        hour   <= h;
        minute <= m;
        second <= s;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_tick(h, m, s);
        ticks_sent++;
    endtask

    // ticks with random time, about a quarter drawn from the full field widths and so possibly outside the clock range
    task automatic send_random_ticks(input int n);
        int         i;
        logic [4:0] h;
        logic [5:0] m;
        logic [5:0] s;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                h = 5'($urandom_range(0, 31));
                m = 6'($urandom_range(0, 63));
                s = 6'($urandom_range(0, 63));
            end else begin
                h = 5'($urandom_range(0, 23));
                m = 6'($urandom_range(0, 59));
                s = 6'($urandom_range(0, 59));
            end
            send_tick(h, m, s);
        end
    endtask

    // register write once the block has drained
    task automatic write_reg(input logic addr, input logic [CFG_W-1:0] value);
        push <= 1'b0;
        while (beats_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == CFG_ON_TICKS)
            on_len = value;
        else
            slot_len = value;
        cfg_writes++;
    endtask

    task automatic set_windows(input logic [CFG_W-1:0] on, input logic [CFG_W-1:0] slot);
        write_reg(CFG_ON_TICKS, on);
        write_reg(CFG_SLOT_TICKS, slot);
    endtask

    // reset windows: the first fifty ticks each send a slot 0 frame
    task automatic test_reset_defaults();
        send_random_ticks(60);
    endtask

    // two passes over the slots, one tick each, with the colon blink on odd and even seconds
    task automatic test_slot_patterns();
        set_windows(1, 1);
        send_tick(23, 0, 0);
        send_tick(19, 0, 0);
        send_tick(0, 59, 0);
        send_tick(0, 63, 0);
        send_tick(0, 0, 63);
        send_tick(0, 0, 40);
        send_tick(0, 0, 1);
        send_tick(31, 63, 63);
        send_tick(0, 0, 0);
        send_tick(31, 0, 0);
        send_tick(17, 0, 0);
        send_tick(0, 10, 0);
        send_tick(0, 48, 0);
        send_tick(0, 0, 35);
        send_tick(0, 0, 56);
        send_tick(0, 0, 58);
        send_tick(0, 0, 0);
        send_tick(0, 0, 0);
    endtask

    // windows longer than the slot: lowest slot takes the tick
    task automatic test_overlap_windows();
        set_windows(3, 1);
        send_random_ticks(12);
    endtask

    // no window at all, then zero-length slots that end the cycle at once
    task automatic test_zero_windows();
        set_windows(0, 3);
        send_random_ticks(30);
        set_windows(2, 0);
        send_random_ticks(10);
    endtask

    // widest windows, then a short run with the longest slots and no idling
    task automatic test_extreme_windows();
        set_windows(8191, 8191);
        send_random_ticks(20);
        set_windows(8191, 1);
        send_random_ticks(20);
        set_windows(1, 8191);
        calm = 1'b1;
        send_random_ticks(10);
        calm = 1'b0;
    endtask

    // short random windows so every slot is reached many times
    task automatic test_random_scan();
        int setting;
        int slot;
        for (setting = 0; setting < 6; setting++) begin
            slot = $urandom_range(1, 10);
            set_windows(CFG_W'($urandom_range(1, slot + 4)), CFG_W'(slot));
            calm = (setting == 3);
            send_random_ticks(30);
        end
        calm = 1'b0;
    endtask

    // result side: random pop and a check of every beat taken
    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            if (beats_due.size() == 0) begin
                report_mismatch($sformatf("beat %0d arrived with none expected", beats_checked));
            end else begin
                want = beats_due.pop_front();
                if (data_bit !== want.data_bit)
                    report_mismatch($sformatf("beat %0d data_bit %b, expected %b",
                                              beats_checked, data_bit, want.data_bit));
                if (last !== want.last)
                    report_mismatch($sformatf("beat %0d last %b, expected %b",
                                              beats_checked, last, want.last));
            end
            beats_checked++;
        end
        pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // watchdog on cycles with no beat taken on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("timeout: no beat for %0d cycles", quiet_cycles);
                    $display("clock_display_scan_serializer: mismatch");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_slot_patterns();
        test_overlap_windows();
        test_zero_windows();
        test_extreme_windows();
        test_random_scan();

        // drain and let any late beat show up
        push <= 1'b0;
        while (beats_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (beats_due.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", beats_due.size()));

        $display("%0d scan ticks over %0d register writes, %0d quiet, %0d beats checked",
                 ticks_sent, cfg_writes, quiet_ticks, beats_checked);
        $display("frames per slot: %0d %0d %0d %0d %0d %0d %0d %0d",
                 slot_hits[0], slot_hits[1], slot_hits[2], slot_hits[3],
                 slot_hits[4], slot_hits[5], slot_hits[6], slot_hits[7]);
        if (mismatches == 0)
            $display("clock_display_scan_serializer: match");
        else
            $display("clock_display_scan_serializer: mismatch");
        $finish;
    end

endmodule

[clock_display_scan_serializer.f]
design/cdss_pkg.sv
design/cdss_front.sv
design/cdss_queue.sv
design/cdss_back.sv
design/clock_display_scan_serializer.sv
design/cdss_checker.sv
sim/testbench.sv
